// ===== hw/rtl/dotq_pkg.sv =====
// Shared types and constants for the deadline ordered timer queue.
package dotq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int SEQ_W  = 32;
    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int MS_W   = 20;
    localparam int FILL_W = 5;
    localparam int STAT_W = 2;

    // now_usec + 1000 * timeout_ms stays below 2^30
    localparam int SUM_W  = 30;
    // quotient of that sum by one million stays below 2^11
    localparam int QUO_W  = 11;

    localparam logic [SUM_W-1:0] USEC_PER_SEC = SUM_W'(1000000);
    localparam logic [SUM_W-1:0] USEC_PER_MS  = SUM_W'(1000);

    // one million is 2^6 * 15625: shift out the 2^6, then multiply by a
    // reciprocal of 15625 scaled by 2^38 (exact for every 24 bit dividend)
    localparam int PRE_SHIFT   = 6;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 38;
    localparam int PROD_W      = SUM_W - PRE_SHIFT + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_15625 = RECIP_W'(17592187);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INS,
        ST_SCAN,
        ST_PLACE,
        ST_POP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
    } entry_t;

    // strictly earlier deadline: seconds first, then microseconds
    function automatic logic earlier(entry_t a, entry_t b);
        logic res;
        if (a.sec != b.sec)
        begin
            res = (a.sec < b.sec);
        end
        else
        begin
            res = (a.usec < b.usec);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/deadline_ordered_timer_queue.sv =====
// Deadline ordered timer queue: sorted store in one synchronous memory.
//
// Input channel (in_valid/in_ready) carries one request: mode 0 inserts a
// timer whose deadline is now + timeout_ms, mode 1 pops the earliest timer.
// Output channel (out_valid/out_ready) returns one result per request:
// status, the entry concerned, and the fill level afterwards.
// One request is worked at a time; in_ready is high only when idle, and the
// next request can be taken the cycle after a result is loaded.
// A pop reads the entry at the head of memory; a pop on empty goes straight to
// the result. An insert forms the sum, divides it by one million with the
// reciprocal, then decides: a full queue rejects it, else entries move up one
// by one to make room. Each moving entry costs one memory read and write.
// Entries sit in a ring addressed from a head pointer; pops only move the
// head. Reset clears the count and the head pointer; memory contents need
// no clearing. A stalled output holds its result; the block may work one
// further request, then waits until the output register is free.
module deadline_ordered_timer_queue
    import dotq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [SEQ_W-1:0]  seq,
    input  logic [MS_W-1:0]   timeout_ms,
    input  logic [SEC_W-1:0]  now_sec,
    input  logic [USEC_W-1:0] now_usec,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [SEQ_W-1:0]  out_seq,
    output logic [SEC_W-1:0]  out_sec,
    output logic [USEC_W-1:0] out_usec,
    output logic [FILL_W-1:0] fill
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = CW + 1;

    state_t state_reg, state_next;

    logic [CW-1:0]   count_reg;
    logic [IW-1:0]   head_reg;
    logic [CW-1:0]   idx_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEC_W-1:0]  nsec_reg;
    entry_t            new_reg;
    entry_t            res_reg;
    status_t           res_stat_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    entry_t            out_reg;
    logic [FILL_W-1:0] fill_reg;

    entry_t            mem [CAPACITY];
    entry_t            rdata_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic [IW-1:0]     mem_raddr;

    logic [PROD_W-1:0] div_prod;
    logic [SUM_W-1:0]  usec_rem;
    logic              new_first;

    // ring position of an offset from the head
    function automatic logic [IW-1:0] phys(logic [IW-1:0] h, logic [CW-1:0] off);
        logic [AW-1:0] s;
        s = AW'(h) + AW'(off);
        if (s >= AW'(CAPACITY))
        begin
            s = s - AW'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    assign div_prod  = PROD_W'(rem_reg[SUM_W-1:PRE_SHIFT]) * PROD_W'(RECIP_15625);
    assign usec_rem  = rem_reg - SUM_W'(quo_reg) * USEC_PER_SEC;
    assign new_first = earlier(rdata_reg, new_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg;
        mem_wdata  = new_reg;
        mem_raddr  = head_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode == MODE_POP)
                    begin
                        state_next = (count_reg == '0) ? ST_RESP : ST_POP;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                state_next = ST_INS;
            end
            ST_INS:
            begin
                mem_raddr = phys(head_reg, count_reg - CW'(1));
                if (count_reg >= CW'(CAPACITY))
                begin
                    state_next = ST_RESP;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg + CW'(1));
                mem_raddr = phys(head_reg, idx_reg - CW'(1));
                if (new_first)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    mem_wdata = rdata_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = ST_RESP;
            end
            ST_POP:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_RESP && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_SCAN:
                begin
                    if (new_first)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                ST_PLACE:
                begin
                    count_reg <= count_reg + CW'(1);
                end
                ST_POP:
                begin
                    count_reg <= count_reg - CW'(1);
                    head_reg  <= (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                seq_reg  <= seq;
                nsec_reg <= now_sec;
                rem_reg  <= SUM_W'(now_usec) + SUM_W'(timeout_ms) * USEC_PER_MS;
                quo_reg  <= '0;
                res_reg      <= '0;
                res_stat_reg <= STAT_EMPTY;
            end
            ST_DIV:
            begin
                quo_reg <= div_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
            end
            ST_INS:
            begin
                new_reg.seq  <= seq_reg;
                new_reg.sec  <= nsec_reg + SEC_W'(quo_reg);
                new_reg.usec <= usec_rem[USEC_W-1:0];
                res_reg.seq  <= seq_reg;
                res_reg.sec  <= nsec_reg + SEC_W'(quo_reg);
                res_reg.usec <= usec_rem[USEC_W-1:0];
                idx_reg      <= count_reg - CW'(1);
                res_stat_reg <= (count_reg >= CW'(CAPACITY)) ? STAT_FULL : STAT_OK;
            end
            ST_SCAN:
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            ST_POP:
            begin
                res_reg      <= rdata_reg;
                res_stat_reg <= STAT_OK;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    status_reg <= res_stat_reg;
                    out_reg    <= res_reg;
                    fill_reg   <= FILL_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // the insert path writes new_reg, set in the decision cycle
    // (an insert into an empty queue lands at the head via ST_PLACE)
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_seq   = out_reg.seq;
    assign out_sec   = out_reg.sec;
    assign out_usec  = out_reg.usec;
    assign fill      = fill_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_PLACE) |-> count_reg < CW'(CAPACITY))
        else $error("shift with a full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not reduce count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL))
        else $error("bad status code");

endmodule
